FILE: src/cmms_pkg.sv
package cmms_pkg;

  localparam int WINDOW      = 7;
  localparam int SAMPLE_BITS = 16;

  localparam int HALF    = WINDOW / 2;
  localparam int LAG     = WINDOW - 1 - HALF;
  localparam int HIST    = WINDOW - 1;
  localparam int FRAC    = 16;
  localparam int ROUND   = 1 << (FRAC - 1);
  localparam int SCALE   = ((1 << FRAC) + HALF) / WINDOW;

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W   = (LAG < 2) ? 1 : $clog2(LAG + 1);
  localparam int SCALE_W = $clog2(SCALE + 1) + 1;
  localparam int PROD_W  = SUM_W + SCALE_W;
  localparam int OUT_W   = SAMPLE_BITS + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH < 2) ? 1 : $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_vector;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] detrended;
    logic                    last_result;
  } result_t;

  // One unit of work for the back end: the window snapshot (oldest first,
  // newest sample on top), the full window sum, and how many leading steps
  // produce no result.
  typedef struct packed {
    logic [WINDOW-1:0][SAMPLE_BITS-1:0] win;
    logic signed [SUM_W-1:0]            s0;
    logic [CNT_W-1:0]                   skip;
    logic                               is_last;
  } job_t;

endpackage

FILE: src/centered_moving_mean_subtract_core.sv
// Channel  | Handshake             | Payload                    | Role
// ---------+-----------------------+----------------------------+-----------------------
// src      | src_valid / src_stall | src_data (sample_t)        | samples in, one vector
// res      | res_valid / res_stall | res_data (result_t)        | detrended samples out
//
// Sustained rate is one sample per cycle while src_stall is low. An accepted sample is
// written into the job queue, then passes the walker, multiply and subtract registers.
// The last sample of a vector makes the back end walk LAG + 1 window positions (4);
// the two-entry job queue absorbs samples before src_stall rises.
// rst is synchronous and clears the window, sum, counters, queue and valids.
// res_stall freezes the whole back pipeline while res_valid is high; src_stall follows only queue full.
module centered_moving_mean_subtract_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  cmms_pkg::sample_t src_data,
  output logic              res_valid,
  input  logic              res_stall,
  output cmms_pkg::result_t res_data
);

  // front -> queue
  logic           push;
  cmms_pkg::job_t push_job;
  logic           q_full;

  // queue -> back
  logic           head_valid;
  cmms_pkg::job_t head;
  logic           pop;

  // Front: keeps the history line and running sum, and turns each sample
  // into a job when it completes a window (or ends the vector).
  cmms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src_valid),
    .in_stall (src_stall),
    .in_data  (src_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Short queue decoupling the sample side from result backpressure.
  cmms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: walks each job's window positions, scales the sum by 1/WINDOW and
  // subtracts; the result register is the output stage.
  cmms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (res_valid),
    .out_stall  (res_stall),
    .out_data   (res_data)
  );

endmodule

FILE: src/cmms_front.sv
module cmms_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cmms_pkg::sample_t in_data,
  input  logic              q_full,
  output logic              push,
  output cmms_pkg::job_t    push_job
);

  logic signed [cmms_pkg::SAMPLE_BITS-1:0] hist [cmms_pkg::HIST];
  logic signed [cmms_pkg::SUM_W-1:0]       total;
  logic [cmms_pkg::CNT_W-1:0]              pend;

  logic                                    acc;
  logic signed [cmms_pkg::SAMPLE_BITS-1:0] x;
  logic                                    pend_full;

  assign in_stall  = q_full;
  assign acc       = in_valid && !q_full;
  assign x         = in_data.sample;
  assign pend_full = (pend == cmms_pkg::CNT_W'(cmms_pkg::LAG));

  always_comb begin
    for (int i = 0; i < cmms_pkg::HIST; i++) begin
      push_job.win[i] = hist[i];
    end
    push_job.win[cmms_pkg::WINDOW-1] = x;
    push_job.s0      = total + cmms_pkg::SUM_W'(x);
    push_job.is_last = in_data.end_of_vector;
    push_job.skip    = in_data.end_of_vector ?
                       cmms_pkg::CNT_W'(cmms_pkg::LAG) - pend : '0;
    push = acc && (in_data.end_of_vector || pend_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cmms_pkg::HIST; i++) begin
        hist[i] <= '0;
      end
      total <= '0;
      pend  <= '0;
    end else if (acc) begin
      if (in_data.end_of_vector) begin
        // vector done: start the next one from an all-zero window
        for (int i = 0; i < cmms_pkg::HIST; i++) begin
          hist[i] <= '0;
        end
        total <= '0;
        pend  <= '0;
      end else begin
        total <= total + cmms_pkg::SUM_W'(x) - cmms_pkg::SUM_W'(hist[0]);
        for (int i = 0; i + 1 < cmms_pkg::HIST; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[cmms_pkg::HIST-1] <= x;
        if (!pend_full) begin
          pend <= pend + 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/cmms_queue.sv
module cmms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cmms_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output cmms_pkg::job_t head
);

  cmms_pkg::job_t              ent [cmms_pkg::QDEPTH];
  logic [cmms_pkg::QPTR_W-1:0] wptr;
  logic [cmms_pkg::QPTR_W-1:0] rptr;
  logic [cmms_pkg::QCNT_W-1:0] cnt;

  assign full       = (cnt == cmms_pkg::QCNT_W'(cmms_pkg::QDEPTH));
  assign head_valid = (cnt != '0);
  assign head       = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == cmms_pkg::QPTR_W'(cmms_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == cmms_pkg::QPTR_W'(cmms_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: src/cmms_back.sv
module cmms_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmms_pkg::job_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output cmms_pkg::result_t out_data
);

  localparam logic signed [cmms_pkg::PROD_W-1:0] SCALE_X =
    cmms_pkg::PROD_W'(cmms_pkg::SCALE);
  localparam logic signed [cmms_pkg::PROD_W-1:0] ROUND_X =
    cmms_pkg::PROD_W'(cmms_pkg::ROUND);

  // walker state
  logic                                                 active;
  logic [cmms_pkg::CNT_W-1:0]                           k;
  logic [cmms_pkg::WINDOW-1:0][cmms_pkg::SAMPLE_BITS-1:0] win;
  logic signed [cmms_pkg::SUM_W-1:0]                    s;

  logic [cmms_pkg::WINDOW-1:0][cmms_pkg::SAMPLE_BITS-1:0] cur_win;
  logic signed [cmms_pkg::SUM_W-1:0]                    cur_s;
  logic [cmms_pkg::CNT_W-1:0]                           cur_k;
  logic                                                 en;
  logic                                                 step;
  logic                                                 emit;
  logic                                                 final_step;

  // math pipeline
  logic                                    v1;
  logic signed [cmms_pkg::SAMPLE_BITS-1:0] x1;
  logic signed [cmms_pkg::SUM_W-1:0]       s1;
  logic                                    l1;
  logic                                    v2;
  logic signed [cmms_pkg::SAMPLE_BITS-1:0] x2;
  logic signed [cmms_pkg::PROD_W-1:0]      p2;
  logic                                    l2;
  logic signed [cmms_pkg::PROD_W-1:0]      prod;
  logic signed [cmms_pkg::PROD_W-1:0]      diff;

  assign en = !(out_valid && out_stall);

  always_comb begin
    cur_win    = active ? win : head.win;
    cur_s      = active ? s : head.s0;
    cur_k      = active ? k : '0;
    step       = en && head_valid;
    emit       = (cur_k >= head.skip);
    final_step = !head.is_last || (cur_k == cmms_pkg::CNT_W'(cmms_pkg::LAG));
    pop        = step && final_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (step) begin
      active <= !final_step;
    end
  end

  // window slides down one place per step; the sample leaving the low end
  // drops out of the sum for the next position
  always_ff @(posedge clk) begin
    if (step) begin
      k <= cur_k + 1'b1;
      s <= cur_s - cmms_pkg::SUM_W'($signed(cur_win[0]));
      for (int i = 0; i + 1 < cmms_pkg::WINDOW; i++) begin
        win[i] <= cur_win[i+1];
      end
      win[cmms_pkg::WINDOW-1] <= '0;
    end
  end

  assign prod = cmms_pkg::PROD_W'(s1) * SCALE_X + ROUND_X;
  assign diff = cmms_pkg::PROD_W'(x2) - (p2 >>> cmms_pkg::FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= step && emit;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= $signed(cur_win[cmms_pkg::HALF]);
      s1 <= cur_s;
      l1 <= head.is_last && final_step;
      x2 <= x1;
      p2 <= prod;
      l2 <= l1;
      out_data.detrended   <= diff[cmms_pkg::OUT_W-1:0];
      out_data.last_result <= l2;
    end
  end

endmodule
